[sv/ertm_pkg.sv]
`timescale 1ns / 1ps
package ertm_pkg;

    // Channel and field widths
    localparam int NCH    = 3;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 16;
    localparam int EXPO_W = 8;
    localparam int FRAC_W = 17;
    localparam int PROD_W = IN_W + FRAC_W;
    localparam int SH_W   = PROD_W + 7;
    localparam int S_W    = 32;
    localparam int REM_W  = S_W + 1;

    // One in Q16.16, widened to the remainder width
    localparam logic [REM_W-1:0] ONE_Q16 = REM_W'(65536);
    // Right shift for integer stops -8 .. -1 is this base minus the low stop bits
    localparam logic [4:0] NEG_SHIFT_BASE = 5'd24;

    // Partial division state for one channel
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] den;
        logic [OUT_W-1:0] quo;
    } div_lane_t;

    typedef div_lane_t [NCH-1:0] div_row_t;

    // 2^(f/16) in Q1.16, rounded
    function automatic logic [FRAC_W-1:0] pow2_frac(input logic [3:0] f);
        logic [FRAC_W-1:0] v;
        unique case (f)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd68438;
            4'd2:  v = 17'd71468;
            4'd3:  v = 17'd74632;
            4'd4:  v = 17'd77936;
            4'd5:  v = 17'd81386;
            4'd6:  v = 17'd84990;
            4'd7:  v = 17'd88752;
            4'd8:  v = 17'd92682;
            4'd9:  v = 17'd96785;
            4'd10: v = 17'd101070;
            4'd11: v = 17'd105545;
            4'd12: v = 17'd110218;
            4'd13: v = 17'd115098;
            4'd14: v = 17'd120194;
            4'd15: v = 17'd125515;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

[sv/exposure_reinhard_tone_mapper_top.sv]
`timescale 1ns / 1ps
// Stages: one multiply stage, one shift stage, one cell per quotient bit, each registered.
// Throughput: one pixel per clock; busy stays low, as the receiver cannot stall.
// Reset: rst_n clears all valid flags and sets the exposure to zero stops.
module exposure_reinhard_tone_mapper_top #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ertm_pkg::IN_W-1:0]       hdr_red,
    input  logic [ertm_pkg::IN_W-1:0]       hdr_green,
    input  logic [ertm_pkg::IN_W-1:0]       hdr_blue,
    output logic                            done,
    output logic [ertm_pkg::OUT_W-1:0]      mapped_red,
    output logic [ertm_pkg::OUT_W-1:0]      mapped_green,
    output logic [ertm_pkg::OUT_W-1:0]      mapped_blue,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ertm_pkg::EXPO_W-1:0]     cfg_data
);
    import ertm_pkg::*;

    logic [EXPO_W-1:0]        expo_reg;
    logic [EXPO_W-1:0]        expo_next;
    logic                     accept;
    logic [NCH-1:0][IN_W-1:0] pix;
    logic                     valid_w [0:OUT_FRAC_BITS];
    div_row_t                 row_w   [0:OUT_FRAC_BITS];

    // The pipeline never stalls, so requests and writes are always taken
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Exposure register
    always_comb begin
        expo_next = expo_reg;
        if (cfg_valid && cfg_ready) begin
            expo_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expo_reg <= '0;
        end
        else begin
            expo_reg <= expo_next;
        end
    end

    assign pix[0] = hdr_red;
    assign pix[1] = hdr_green;
    assign pix[2] = hdr_blue;

    // Scale by two to the exposure
    ertm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .pix       (pix),
        .expo      (expo_reg),
        .valid_out (valid_w[0]),
        .row_out   (row_w[0])
    );

    // Row of divider cells, one quotient bit each
    for (genvar k = 0; k < OUT_FRAC_BITS; k++) begin : g_cell
        ertm_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_w[k]),
            .row_in    (row_w[k]),
            .valid_out (valid_w[k+1]),
            .row_out   (row_w[k+1])
        );
    end

    // Present the last cell's quotient
    assign done         = valid_w[OUT_FRAC_BITS];
    assign mapped_red   = row_w[OUT_FRAC_BITS][0].quo;
    assign mapped_green = row_w[OUT_FRAC_BITS][1].quo;
    assign mapped_blue  = row_w[OUT_FRAC_BITS][2].quo;

endmodule

[sv/ertm_scale.sv]
`timescale 1ns / 1ps
module ertm_scale (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        valid_in,
    input  logic [ertm_pkg::NCH-1:0][ertm_pkg::IN_W-1:0] pix,
    input  logic [ertm_pkg::EXPO_W-1:0]                 expo,
    output logic                                        valid_out,
    output ertm_pkg::div_row_t                          row_out
);
    import ertm_pkg::*;

    logic [NCH-1:0][PROD_W-1:0] prod_reg;
    logic [3:0]                 hi_reg;
    logic                       valid_a_reg;
    logic                       valid_b_reg;
    div_row_t                   row_next;
    div_row_t                   row_reg;
    logic [FRAC_W-1:0]          frac;
    logic [4:0]                 rsh;

    assign frac = pow2_frac(expo[3:0]);
    assign rsh  = NEG_SHIFT_BASE - {2'b00, hi_reg[2:0]};

    // Hold valid flags of both stages
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else begin
            valid_a_reg <= valid_in;
            valid_b_reg <= valid_a_reg;
        end
    end

    // Multiply each channel by the fractional factor
    always_ff @(posedge clk) begin
        for (int c = 0; c < NCH; c++) begin
            prod_reg[c] <= PROD_W'(pix[c]) * PROD_W'(frac);
        end
        hi_reg <= expo[7:4];
    end

    // Apply the integer stops and seed the divider row
    always_comb begin
        logic [SH_W-1:0] left;
        logic [S_W-1:0]  s_pos;
        logic [S_W-1:0]  s_neg;
        logic [S_W-1:0]  s;
        row_next = '0;
        for (int c = 0; c < NCH; c++) begin
            left  = {{(SH_W-PROD_W){1'b0}}, prod_reg[c]} << hi_reg[2:0];
            s_pos = left[SH_W-1:SH_W-S_W];
            s_neg = S_W'(prod_reg[c] >> rsh);
            s     = hi_reg[3] ? s_neg : s_pos;
            // Q16.16 cannot overflow here: 24 bits times 2^(15/16) times 2^7 stays below 2^32
            row_next[c].rem = {1'b0, s};
            row_next[c].den = {1'b0, s} + ONE_Q16;
            row_next[c].quo = '0;
        end
    end

    always_ff @(posedge clk) begin
        row_reg <= row_next;
    end

    assign valid_out = valid_b_reg;
    assign row_out   = row_reg;

endmodule

[sv/ertm_div_cell.sv]
`timescale 1ns / 1ps
module ertm_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  ertm_pkg::div_row_t row_in,
    output logic               valid_out,
    output ertm_pkg::div_row_t row_out
);
    import ertm_pkg::*;

    logic     valid_reg;
    div_row_t row_next;
    div_row_t row_reg;

    // Double the remainder and subtract the divisor where it fits
    always_comb begin
        logic [REM_W:0] two;
        logic [REM_W:0] diff;
        for (int c = 0; c < NCH; c++) begin
            two  = {row_in[c].rem, 1'b0};
            diff = two - {1'b0, row_in[c].den};
            row_next[c].den = row_in[c].den;
            if (!diff[REM_W]) begin
                row_next[c].rem = diff[REM_W-1:0];
                row_next[c].quo = {row_in[c].quo[OUT_W-2:0], 1'b1};
            end
            else begin
                row_next[c].rem = two[REM_W-1:0];
                row_next[c].quo = {row_in[c].quo[OUT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk) begin
        row_reg <= row_next;
    end

    assign valid_out = valid_reg;
    assign row_out   = row_reg;

endmodule

[sv/ertm_checker.sv]
`timescale 1ns / 1ps
module ertm_checker #(
    parameter int OUT_FRAC_BITS = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [ertm_pkg::IN_W-1:0]   hdr_red,
    input logic                        done,
    input logic [ertm_pkg::OUT_W-1:0]  mapped_red,
    input logic                        cfg_ready
);
    import ertm_pkg::*;

    localparam int LAT = OUT_FRAC_BITS + 2;

    // Every request yields a result after the fixed latency
    a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request produced no result");

    // No result without a request
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // A black red channel maps to zero
    a_zero_maps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && hdr_red == '0) |-> ##LAT (mapped_red == '0))
        else $error("zero input gave nonzero output");

    // Never hold off requests or writes
    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && cfg_ready)
        else $error("block refused a request");

endmodule

bind exposure_reinhard_tone_mapper_top ertm_checker #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_ertm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .hdr_red    (hdr_red),
    .done       (done),
    .mapped_red (mapped_red),
    .cfg_ready  (cfg_ready)
);
